/* rtl/core/otm_pkg.sv */
// ----------------------------------------------------------------------------
// otm_pkg
// Shared types and constants for the one-edit typo matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package otm_pkg;

    localparam int MAX_WORD_LEN_DEF = 32;

    // command queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_QUERY_CHAR = 2'd0;
    localparam logic [1:0] OP_DICT_CHAR  = 2'd1;
    localparam logic [1:0] OP_WORD_END   = 2'd2;
    localparam logic [1:0] OP_LIST_END   = 2'd3;

    localparam logic [1:0] SCORE_EXACT = 2'd0;
    localparam logic [1:0] SCORE_ONE   = 2'd1;
    localparam logic [1:0] SCORE_NONE  = 2'd2;
    localparam logic [1:0] SCORE_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        CMD_QUERY,
        CMD_CHAR,
        CMD_WORD_END,
        CMD_LIST_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] character;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/otm_front.sv */
// ----------------------------------------------------------------------------
// otm_front
// Accepts input beats, decodes the operation and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module otm_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic [1:0]    operation,
    input  wire logic [7:0]    character,
    output logic               cmd_valid,
    output otm_pkg::cmd_t      cmd,
    input  wire logic          cmd_pop
);
    import otm_pkg::*;

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    cmd_t              decoded;

    always_comb
    begin
        decoded.character = character;
        case (operation)
            OP_QUERY_CHAR: decoded.kind = CMD_QUERY;
            OP_DICT_CHAR:  decoded.kind = CMD_CHAR;
            OP_WORD_END:   decoded.kind = CMD_WORD_END;
            default:       decoded.kind = CMD_LIST_END;
        endcase
    end

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/otm_back.sv */
// ----------------------------------------------------------------------------
// otm_back
// Query store, edit path trackers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module otm_back
#(
    parameter int MAX_WORD_LEN = otm_pkg::MAX_WORD_LEN_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire otm_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [1:0]         score_code,
    output logic               overlong_seen
);
    import otm_pkg::*;

    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    logic [7:0]        query_mem [MAX_WORD_LEN];

    logic [LEN_W-1:0]  qlen_reg, qlen_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [1:0]        mis_reg, mis_next;
    logic              pend_v_reg, pend_v_next;
    logic [7:0]        pend_c_reg, pend_c_next;
    logic              swap_reg, swap_next;
    logic              ins_reg, ins_next;
    logic              ins_skip_reg, ins_skip_next;
    logic              del_reg, del_next;
    logic              del_skip_reg, del_skip_next;
    logic              qlong_reg, qlong_next;
    logic [1:0]        best_reg, best_next;
    logic              seen_reg, seen_next;
    logic              ovf_reg, ovf_next;
    logic              qopen_reg, qopen_next;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_score_reg, res_score_next;
    logic              res_ovf_reg, res_ovf_next;

    // sliding window: q[p-1], q[p], q[p+1] (last one from the memory port)
    logic [7:0]        qa_reg, qa_next;
    logic [7:0]        qb_reg, qb_next;
    logic [7:0]        q0_reg, q0_next;
    logic [7:0]        rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [LEN_W:0]    rd_idx;

    logic [LEN_W:0]    pos_ext;
    logic [LEN_W:0]    qlen_ext;
    logic [LEN_W:0]    pos_plus1;
    logic              eq_cur;
    logic              eq_next;
    logic              eq_prev;
    logic [1:0]        score;
    logic [7:0]        c;

    assign c         = cmd.character;
    assign pos_ext   = {1'b0, pos_reg};
    assign qlen_ext  = {1'b0, qlen_reg};
    assign pos_plus1 = pos_ext + 1'b1;
    assign eq_cur    = (pos_reg < qlen_reg) && (qb_reg == c);
    assign eq_next   = (pos_plus1 < qlen_ext) && (rd_data_reg == c);
    assign eq_prev   = (pos_reg != '0) && (pos_reg <= qlen_reg) && (qa_reg == c);

    assign cmd_pop = cmd_valid &&
                     ((cmd.kind != CMD_LIST_END) || !res_valid_reg || !result_stall);

    always_comb
    begin
        qlen_next      = qlen_reg;
        pos_next       = pos_reg;
        mis_next       = mis_reg;
        pend_v_next    = pend_v_reg;
        pend_c_next    = pend_c_reg;
        swap_next      = swap_reg;
        ins_next       = ins_reg;
        ins_skip_next  = ins_skip_reg;
        del_next       = del_reg;
        del_skip_next  = del_skip_reg;
        qlong_next     = qlong_reg;
        best_next      = best_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        qopen_next     = qopen_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        q0_next        = q0_reg;
        res_score_next = res_score_reg;
        res_ovf_next   = res_ovf_reg;
        res_valid_next = res_valid_reg && result_stall;
        mem_we         = 1'b0;
        mem_waddr      = qlen_reg[ADDR_W-1:0];
        score          = SCORE_NONE;

        if (cmd_pop)
        begin
            case (cmd.kind)
                CMD_QUERY:
                begin
                    if (qopen_reg)
                    begin
                        if (qlen_reg < LEN_W'(MAX_WORD_LEN))
                        begin
                            mem_we    = 1'b1;
                            qlen_next = qlen_reg + 1'b1;
                            if (qlen_reg == '0)
                            begin
                                q0_next = c;
                                qb_next = c;
                            end
                        end
                        else
                        begin
                            ovf_next      = 1'b1;
                            qlong_next    = 1'b1;
                            mis_next      = 2'd3;
                            pend_v_next   = 1'b0;
                            pend_c_next   = '0;
                            swap_next     = 1'b0;
                            ins_next      = 1'b0;
                            ins_skip_next = 1'b0;
                            del_next      = 1'b0;
                            del_skip_next = 1'b0;
                        end
                    end
                end
                CMD_CHAR:
                begin
                    qopen_next = 1'b0;
                    if (pos_reg >= LEN_W'(MAX_WORD_LEN))
                    begin
                        ovf_next      = 1'b1;
                        mis_next      = 2'd3;
                        pend_v_next   = 1'b0;
                        pend_c_next   = '0;
                        swap_next     = 1'b0;
                        ins_next      = 1'b0;
                        ins_skip_next = 1'b0;
                        del_next      = 1'b0;
                        del_skip_next = 1'b0;
                    end
                    else
                    begin
                        if (swap_reg)
                        begin
                            if (pend_v_reg)
                            begin
                                if (c == pend_c_reg)
                                begin
                                    pend_v_next = 1'b0;
                                    pend_c_next = '0;
                                end
                                else
                                begin
                                    swap_next = 1'b0;
                                end
                            end
                            else if ((pos_reg < qlen_reg) && !eq_cur)
                            begin
                                if ((mis_reg == 2'd0) && eq_next)
                                begin
                                    pend_v_next = 1'b1;
                                    pend_c_next = qb_reg;
                                end
                                else
                                begin
                                    swap_next = 1'b0;
                                end
                            end
                        end
                        if (ins_reg)
                        begin
                            if (!ins_skip_reg)
                            begin
                                if (!eq_cur)
                                begin
                                    ins_skip_next = 1'b1;
                                end
                            end
                            else if (!eq_prev)
                            begin
                                ins_next = 1'b0;
                            end
                        end
                        if (del_reg)
                        begin
                            if (!del_skip_reg)
                            begin
                                if (!eq_cur)
                                begin
                                    if (eq_next)
                                    begin
                                        del_skip_next = 1'b1;
                                    end
                                    else
                                    begin
                                        del_next = 1'b0;
                                    end
                                end
                            end
                            else if (!eq_next)
                            begin
                                del_next = 1'b0;
                            end
                        end
                        if (!eq_cur && (mis_reg != 2'd3))
                        begin
                            mis_next = mis_reg + 1'b1;
                        end
                        pos_next = pos_reg + 1'b1;
                        qa_next  = qb_reg;
                        qb_next  = rd_data_reg;
                    end
                end
                CMD_WORD_END:
                begin
                    qopen_next = 1'b0;
                    seen_next  = 1'b1;
                    if ((pos_reg == qlen_reg) && (mis_reg == 2'd0))
                    begin
                        score = SCORE_EXACT;
                    end
                    else if (((pos_reg == qlen_reg) && (mis_reg == 2'd1)) ||
                             (swap_reg && !pend_v_reg && (pos_reg == qlen_reg) &&
                              (mis_reg == 2'd2)) ||
                             (ins_reg && (pos_ext == qlen_ext + 1'b1)) ||
                             (del_reg && (pos_plus1 == qlen_ext)))
                    begin
                        score = SCORE_ONE;
                    end
                    if (score < best_reg)
                    begin
                        best_next = score;
                    end
                    // next word; an overlong query leaves every path dead
                    pos_next      = '0;
                    qb_next       = q0_reg;
                    pend_v_next   = 1'b0;
                    pend_c_next   = '0;
                    ins_skip_next = 1'b0;
                    del_skip_next = 1'b0;
                    mis_next      = qlong_reg ? 2'd3 : 2'd0;
                    swap_next     = !qlong_reg;
                    ins_next      = !qlong_reg;
                    del_next      = !qlong_reg;
                end
                default:
                begin
                    res_valid_next = 1'b1;
                    res_score_next = seen_reg ? best_reg : SCORE_EMPTY;
                    res_ovf_next   = ovf_reg;
                    qlen_next      = '0;
                    pos_next       = '0;
                    mis_next       = 2'd0;
                    pend_v_next    = 1'b0;
                    pend_c_next    = '0;
                    swap_next      = 1'b1;
                    ins_next       = 1'b1;
                    ins_skip_next  = 1'b0;
                    del_next       = 1'b1;
                    del_skip_next  = 1'b0;
                    qlong_next     = 1'b0;
                    best_next      = SCORE_NONE;
                    seen_next      = 1'b0;
                    ovf_next       = 1'b0;
                    qopen_next     = 1'b1;
                end
            endcase
        end

        // fetch q[p+1] for the position that the next beat will see
        rd_idx    = {1'b0, pos_next} + 1'b1;
        mem_raddr = rd_idx[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            query_mem[mem_waddr] <= c;
        end
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            rd_data_reg <= c;
        end
        else
        begin
            rd_data_reg <= query_mem[mem_raddr];
        end
        qa_reg        <= qa_next;
        qb_reg        <= qb_next;
        q0_reg        <= q0_next;
        pend_c_reg    <= pend_c_next;
        res_score_reg <= res_score_next;
        res_ovf_reg   <= res_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            pos_reg       <= '0;
            mis_reg       <= 2'd0;
            pend_v_reg    <= 1'b0;
            swap_reg      <= 1'b1;
            ins_reg       <= 1'b1;
            ins_skip_reg  <= 1'b0;
            del_reg       <= 1'b1;
            del_skip_reg  <= 1'b0;
            qlong_reg     <= 1'b0;
            best_reg      <= SCORE_NONE;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            qopen_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            qlen_reg      <= qlen_next;
            pos_reg       <= pos_next;
            mis_reg       <= mis_next;
            pend_v_reg    <= pend_v_next;
            swap_reg      <= swap_next;
            ins_reg       <= ins_next;
            ins_skip_reg  <= ins_skip_next;
            del_reg       <= del_next;
            del_skip_reg  <= del_skip_next;
            qlong_reg     <= qlong_next;
            best_reg      <= best_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            qopen_reg     <= qopen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign score_code    = res_score_reg;
    assign overlong_seen = res_ovf_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("word position beyond max length");

    a_qlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("query length beyond max length");

    a_qlong_dead: assert property (@(posedge clk) disable iff (!rst_n)
        qlong_reg |-> (!swap_reg && !ins_reg && !del_reg && (mis_reg == 2'd3)))
        else $error("edit path alive with overlong query");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd.kind == CMD_LIST_END)) |-> !(res_valid_reg && result_stall))
        else $error("list end taken while result held");

    a_query_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (!qopen_reg && !(cmd_pop && (cmd.kind == CMD_LIST_END))) |=> $stable(qlen_reg))
        else $error("query length moved after query closed");

endmodule

`default_nettype wire

/* rtl/core/one_edit_typo_matcher_core.sv */
// ----------------------------------------------------------------------------
// one_edit_typo_matcher_core
// Scores a list of dictionary words against a stored query word.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while no end-of-list beat waits on a stalled
//   result; the two-entry command queue and the path update in the back end set this rate.
// Result: result_valid rises from a register set when the back end takes the end-of-list
//   beat from the queue; that beat waits in the queue while an earlier result is still stalled.
// Reset: rst_n clears all control state at once; the query store is not
//   cleared and needs no clearing pass, so beats are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module one_edit_typo_matcher_core
#(
    parameter int MAX_WORD_LEN = otm_pkg::MAX_WORD_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] character,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [1:0]      score_code,
    output logic            overlong_seen
);
    import otm_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    otm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .character  (character),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    otm_back #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .score_code    (score_code),
        .overlong_seen (overlong_seen)
    );

endmodule

`default_nettype wire

/* tb/tb_one_edit_typo_matcher_core.sv */
// ----------------------------------------------------------------------------
// tb_one_edit_typo_matcher_core
// Drives query and dictionary beats into the typo matcher and checks each
// end-of-list score against a cycle-free predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_edit_typo_matcher_core;

    timeunit 1ns;
    timeprecision 1ps;

    import otm_pkg::*;

    localparam int WORD_MAX    = MAX_WORD_LEN_DEF;
    localparam int ITEMS_TOTAL = 1775;

    typedef logic [7:0] byte_q_t[$];

    typedef enum int {
        EDIT_REPLACE,
        EDIT_INSERT,
        EDIT_DELETE,
        EDIT_SWAP
    } edit_t;

    typedef struct packed {
        logic [1:0] score;
        logic       overlong;
    } verdict_t;

    class typo_scoreboard;
        logic [7:0] qbytes [WORD_MAX];
        logic [5:0] qlen;
        logic [5:0] wpos;
        logic [1:0] mism;
        logic       swap_pend;
        logic [7:0] swap_char;
        logic       swap_ok, ins_ok, ins_skip, del_ok, del_skip, q_long;
        logic [1:0] best;
        logic       seen, ovf, q_open;
        verdict_t   verdicts[$];
        int         fails;

        function new();
            fails = 0;
            q_long = 1'b0;
            clear_list();
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            fails++;
        endfunction

        function bit char_at(int idx, logic [7:0] c);
            return idx >= 0 && idx < int'(qlen) && idx < WORD_MAX && qbytes[idx] == c;
        endfunction

        function void kill_word();
            mism      = 2'd3;
            swap_pend = 1'b0;
            swap_char = 8'h00;
            swap_ok   = 1'b0;
            ins_ok    = 1'b0;
            ins_skip  = 1'b0;
            del_ok    = 1'b0;
            del_skip  = 1'b0;
        endfunction

        function void open_word();
            wpos      = 6'd0;
            mism      = 2'd0;
            swap_pend = 1'b0;
            swap_char = 8'h00;
            swap_ok   = 1'b1;
            ins_ok    = 1'b1;
            ins_skip  = 1'b0;
            del_ok    = 1'b1;
            del_skip  = 1'b0;
            if (q_long)
                kill_word();
        endfunction

        function void clear_list();
            qlen   = 6'd0;
            best   = SCORE_NONE;
            seen   = 1'b0;
            ovf    = 1'b0;
            q_open = 1'b1;
            q_long = 1'b0;
            open_word();
        endfunction

        function void dict_char(logic [7:0] c);
            int  p;
            bit  hit;
            logic [1:0] prior;
            p     = int'(wpos);
            prior = mism;
            if (p >= WORD_MAX)
            begin
                ovf = 1'b1;
                kill_word();
                return;
            end
            hit = char_at(p, c);

            // adjacent swap: first mismatch must be the next query byte
            if (swap_ok)
            begin
                if (swap_pend)
                begin
                    if (c == swap_char)
                    begin
                        swap_pend = 1'b0;
                        swap_char = 8'h00;
                    end
                    else
                        swap_ok = 1'b0;
                end
                else if (p < int'(qlen) && !hit)
                begin
                    if (prior == 2'd0 && char_at(p + 1, c))
                    begin
                        swap_pend = 1'b1;
                        swap_char = qbytes[p];
                    end
                    else
                        swap_ok = 1'b0;
                end
            end

            if (ins_ok)
            begin
                if (!ins_skip)
                begin
                    if (!hit)
                        ins_skip = 1'b1;
                end
                else if (p == 0 || !char_at(p - 1, c))
                    ins_ok = 1'b0;
            end

            if (del_ok)
            begin
                if (!del_skip)
                begin
                    if (!hit)
                    begin
                        if (char_at(p + 1, c))
                            del_skip = 1'b1;
                        else
                            del_ok = 1'b0;
                    end
                end
                else if (!char_at(p + 1, c))
                    del_ok = 1'b0;
            end

            if (!hit && mism != 2'd3)
                mism = mism + 2'd1;
            wpos = wpos + 6'd1;
        endfunction

        function void close_word();
            int len;
            int ql;
            logic [1:0] score;
            len   = int'(wpos);
            ql    = int'(qlen);
            score = SCORE_NONE;
            seen  = 1'b1;
            if (len == ql && mism == 2'd0)
                score = SCORE_EXACT;
            else if ((len == ql && mism == 2'd1) ||
                     (swap_ok && !swap_pend && len == ql && mism == 2'd2) ||
                     (ins_ok && len == ql + 1) ||
                     (del_ok && len + 1 == ql))
                score = SCORE_ONE;
            if (score < best)
                best = score;
            open_word();
        endfunction

        function void note_beat(logic [1:0] op, logic [7:0] c);
            verdict_t v;
            case (op)
                OP_QUERY_CHAR:
                begin
                    if (q_open)
                    begin
                        if (int'(qlen) < WORD_MAX)
                        begin
                            qbytes[qlen] = c;
                            qlen = qlen + 6'd1;
                        end
                        else
                        begin
                            ovf    = 1'b1;
                            q_long = 1'b1;
                            kill_word();
                        end
                    end
                end
                OP_DICT_CHAR:
                begin
                    q_open = 1'b0;
                    dict_char(c);
                end
                OP_WORD_END:
                begin
                    q_open = 1'b0;
                    close_word();
                end
                default:
                begin
                    v.score    = seen ? best : SCORE_EMPTY;
                    v.overlong = ovf;
                    verdicts.push_back(v);
                    clear_list();
                end
            endcase
        endfunction

        function void check_result(logic [1:0] score, logic overlong);
            verdict_t v;
            if (verdicts.size() == 0)
            begin
                report($sformatf("unexpected result score=%0d overlong=%0b", score, overlong));
                return;
            end
            v = verdicts.pop_front();
            if (score !== v.score)
                report($sformatf("score_code got %0d want %0d", score, v.score));
            if (overlong !== v.overlong)
                report($sformatf("overlong_seen got %0b want %0b", overlong, v.overlong));
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic [1:0] operation    = OP_QUERY_CHAR;
    logic [7:0] character    = 8'h00;
    logic       result_stall = 1'b0;
    logic       item_stall;
    logic       result_valid;
    logic [1:0] score_code;
    logic       overlong_seen;

    typo_scoreboard sb;
    logic [7:0]     alpha [3];
    bit             idle_on   = 1'b1;
    int             gap_pct   = 10;
    int             stall_pct = 20;
    int             beats_sent = 0;

    one_edit_typo_matcher_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .character     (character),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .score_code    (score_code),
        .overlong_seen (overlong_seen)
    );

    always #5 clk = ~clk;

    // handshake is sampled at the falling edge, where everything has settled
    task automatic send_beat(input logic [1:0] op, input logic [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 18);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        character  <= c;
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
        sb.note_beat(op, c);
        beats_sent++;
    endtask

    task automatic send_word(input byte_q_t w);
        foreach (w[i])
            send_beat(OP_DICT_CHAR, w[i]);
        send_beat(OP_WORD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return alpha[$urandom_range(0, 2)];
    endfunction

    function automatic byte_q_t edit_word(byte_q_t w, edit_t kind);
        byte_q_t r;
        int i;
        logic [7:0] t;
        r = w;
        case (kind)
            EDIT_REPLACE:
                if (r.size() > 0)
                begin
                    i = $urandom_range(0, r.size() - 1);
                    r[i] = pick_char();
                end
            EDIT_INSERT:
            begin
                i = $urandom_range(0, r.size());
                r.insert(i, pick_char());
            end
            EDIT_DELETE:
                if (r.size() > 0)
                    r.delete($urandom_range(0, r.size() - 1));
            default:
                if (r.size() > 1)
                begin
                    i = $urandom_range(0, r.size() - 2);
                    t = r[i];
                    r[i] = r[i + 1];
                    r[i + 1] = t;
                end
        endcase
        return r;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    // one query, up to five dictionary words (mostly near misses), then end of list
    task automatic run_list();
        byte_q_t q;
        byte_q_t w;
        int qn;
        int nwords;
        int pick;
        int n;
        foreach (alpha[i])
            alpha[i] = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            qn = $urandom_range(WORD_MAX + 1, WORD_MAX + 4);
        else if (pick < 12)
            qn = WORD_MAX;
        else if (pick < 18)
            qn = 0;
        else if (pick < 30)
            qn = $urandom_range(9, WORD_MAX - 1);
        else
            qn = $urandom_range(1, 8);
        q = {};
        repeat (qn)
            q.push_back(pick_char());
        foreach (q[i])
            send_beat(OP_QUERY_CHAR, q[i]);

        nwords = $urandom_range(0, 5);
        repeat (nwords)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0, 1: w = q;
                2:    w = edit_word(q, EDIT_REPLACE);
                3:    w = edit_word(q, EDIT_INSERT);
                4:    w = edit_word(q, EDIT_DELETE);
                5, 6: w = edit_word(q, EDIT_SWAP);
                7, 8: w = edit_word(edit_word(q, edit_t'($urandom_range(0, 3))),
                                    edit_t'($urandom_range(0, 3)));
                9:
                begin
                    w = {};
                    n = $urandom_range(0, 8);
                    repeat (n)
                        w.push_back(pick_char());
                end
                10:
                begin
                    w = {};
                    n = $urandom_range(WORD_MAX + 1, WORD_MAX + 3);
                    repeat (n)
                        w.push_back(pick_char());
                end
                default: w = {};
            endcase
            send_word(w);
            // query beats after the query closed are dropped
            if ($urandom_range(0, 9) == 0)
                send_beat(OP_QUERY_CHAR, pick_char());
            if ($urandom_range(0, 19) == 0)
                send_beat(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
        end

        // word left open at end of list
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_beat(OP_DICT_CHAR, pick_char());
        end
        send_beat(OP_LIST_END, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int lists;
        sb = new();
        lists = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        send_beat(OP_LIST_END, 8'h00);
        // swapped pair at the byte extremes
        send_beat(OP_QUERY_CHAR, 8'h00);
        send_beat(OP_QUERY_CHAR, 8'hFF);
        send_word('{8'hFF, 8'h00});
        send_beat(OP_LIST_END, 8'hFF);
        // exact word, late query beat, unfinished word
        send_beat(OP_QUERY_CHAR, 8'hA5);
        send_word('{8'hA5});
        send_beat(OP_QUERY_CHAR, 8'h5A);
        send_beat(OP_DICT_CHAR, 8'h5A);
        send_beat(OP_LIST_END, 8'h00);
        // empty word against empty query
        send_beat(OP_WORD_END, 8'h00);
        send_beat(OP_LIST_END, 8'h00);
        // deletion and insertion
        send_beat(OP_QUERY_CHAR, 8'h3C);
        send_beat(OP_QUERY_CHAR, 8'hC3);
        send_beat(OP_QUERY_CHAR, 8'h0F);
        send_word('{8'h3C, 8'h0F});
        send_word('{8'h3C, 8'hC3, 8'hF0, 8'h0F});
        send_beat(OP_LIST_END, 8'h00);

        while (beats_sent < ITEMS_TOTAL)
        begin
            if (beats_sent > ITEMS_TOTAL * 85 / 100)
                idle_on = 1'b0;
            gap_pct   = pick_rate();
            stall_pct = pick_rate();
            run_list();
            lists++;
            if (lists % 8 == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 18) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(score_code, overlong_seen);
        end
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
